/* hw/rtl/sdcs_pkg.sv */
// Package for the stick deadzone and cubic steering conditioner.
// Holds payload structs, the register index codes and the cell data type.
// No dependencies.
package sdcs_pkg;

    localparam int QBITS = 15;

    typedef enum logic [1:0] {
        REG_LINEAR_MODE    = 2'd0,
        REG_SINGLE_STICK   = 2'd1,
        REG_LEFT_DEADZONE  = 2'd2,
        REG_RIGHT_DEADZONE = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic signed [15:0] left_stick_x;
        logic signed [15:0] right_stick_x;
        logic [7:0]         left_trigger;
        logic [7:0]         right_trigger;
    } in_beat_t;

    typedef struct packed {
        logic signed [15:0] wheel;
        logic [15:0]        accel;
        logic [15:0]        brake;
    } out_beat_t;

    // Divider cell data for one stick: partial remainder, divisor, quotient.
    typedef struct packed {
        logic [63:0]      rem;
        logic [45:0]      den;
        logic [QBITS-1:0] quo;
        logic             neg;
        logic             force_full;
        logic             zero;
        logic signed [16:0] lin;
    } stick_t;

    // Sideband carried beside the two sticks through the chain.
    typedef struct packed {
        logic       linear_mode;
        logic       single_stick;
        logic [7:0] left_trigger;
        logic [7:0] right_trigger;
    } side_t;

endpackage

/* hw/rtl/stick_deadzone_cubic_steering.sv */
// Top level of the stick deadzone and cubic steering conditioner.
// Uses sdcs_pkg, sdcs_cube and sdcs_div_cell.
//
// The block accepts one beat per cycle while the output is not stalled, and
// returns one result beat for each input beat, in order. Each stick passes a
// three-stage cube front end, then a chain of 15 division cells that each
// settle one quotient bit of 32767*n^3 / d^3 (the quotient never exceeds 15
// bits once n <= d), then one combine stage that applies sign, saturation,
// linear mode and the wheel average or single-stick choice. The whole pipe
// advances together when the output register is free or being taken, so
// stall on the output holds every stage. Configuration is sampled on entry;
// write it only while idle. Register indexes: 0 linear_mode, 1 single_stick,
// 2 left_deadzone, 3 right_deadzone.
module stick_deadzone_cubic_steering (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [14:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  sdcs_pkg::in_beat_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output sdcs_pkg::out_beat_t  out_data
);
    import sdcs_pkg::*;

    localparam int DEPTH = 3 + QBITS + 1;

    logic        linear_mode_reg, single_stick_reg;
    logic [14:0] left_dz_reg, right_dz_reg;
    logic        adv;
    logic [DEPTH-1:0] vld_reg;

    // Pipe advances unless the final result is held by a stall.
    assign adv      = ~(out_valid && out_stall);
    assign in_stall = ~adv;
    assign out_valid = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            linear_mode_reg  <= 1'b0;
            single_stick_reg <= 1'b0;
            left_dz_reg      <= '0;
            right_dz_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_LINEAR_MODE:    linear_mode_reg  <= cfg_data[0];
                REG_SINGLE_STICK:   single_stick_reg <= cfg_data[0];
                REG_LEFT_DEADZONE:  left_dz_reg      <= cfg_data;
                REG_RIGHT_DEADZONE: right_dz_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
    end

    // Sideband shift line that travels alongside the sticks.
    side_t side_reg [DEPTH-1];
    side_t side_in;
    always_comb
    begin
        side_in.linear_mode   = linear_mode_reg;
        side_in.single_stick  = single_stick_reg;
        side_in.left_trigger  = in_data.left_trigger;
        side_in.right_trigger = in_data.right_trigger;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < DEPTH - 1; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    stick_t l_chain [QBITS+1];
    stick_t r_chain [QBITS+1];

    sdcs_cube u_cube_l (
        .clk(clk), .en(adv),
        .sample(in_data.left_stick_x), .deadzone(left_dz_reg), .result(l_chain[0])
    );
    sdcs_cube u_cube_r (
        .clk(clk), .en(adv),
        .sample(in_data.right_stick_x), .deadzone(right_dz_reg), .result(r_chain[0])
    );

    // Quotient bits from most to least significant, one cell each.
    for (genvar g = 0; g < QBITS; g++)
    begin : g_div
        sdcs_div_cell u_cell_l (
            .clk(clk), .en(adv), .bit_pos(6'(QBITS - 1 - g)),
            .din(l_chain[g]), .dout(l_chain[g+1])
        );
        sdcs_div_cell u_cell_r (
            .clk(clk), .en(adv), .bit_pos(6'(QBITS - 1 - g)),
            .din(r_chain[g]), .dout(r_chain[g+1])
        );
    end

    // Final stage: curve value or linear shrink per stick, then the wheel.
    function automatic logic signed [16:0] stick_value(input stick_t s, input logic lin_mode);
        logic [14:0] mag;
        begin
            if (lin_mode)
                stick_value = s.lin;
            else
            begin
                if (s.zero)
                    mag = '0;
                else if (s.force_full)
                    mag = 15'h7fff;
                else
                    mag = s.quo;
                stick_value = s.neg ? -17'(mag) : 17'(mag);
            end
        end
    endfunction

    side_t              side_last;
    logic signed [16:0] lv, rv;
    logic signed [17:0] sum;
    logic signed [17:0] avg;
    out_beat_t          out_next;
    out_beat_t          out_reg;

    always_comb
    begin
        side_last = side_reg[DEPTH-2];
        lv  = stick_value(l_chain[QBITS], side_last.linear_mode);
        rv  = stick_value(r_chain[QBITS], side_last.linear_mode);
        sum = 18'(lv) + 18'(rv);
        // Truncate toward zero: bias negative sums by one before the shift.
        avg = (sum + (sum[17] ? 18'sd1 : 18'sd0)) >>> 1;
        out_next.wheel = side_last.single_stick ? lv[15:0] : avg[15:0];
        out_next.accel = {side_last.right_trigger, 8'd0};
        out_next.brake = {side_last.left_trigger, 8'd0};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= out_next;
    end

    assign out_data = out_reg;

endmodule

/* hw/rtl/sdcs_cube.sv */
// Front stage: magnitude, deadzone and the cube products n^3 and d^3.
// Registered steps: operands, squares and cubes; depends on sdcs_pkg.
module sdcs_cube (
    input  logic                clk,
    input  logic                en,
    input  logic signed [15:0]  sample,
    input  logic [14:0]         deadzone,
    output sdcs_pkg::stick_t    result
);
    import sdcs_pkg::*;

    logic [15:0] mag;
    logic [16:0] n_wide;
    logic [15:0] d_s0;
    logic        neg_s0;
    logic        below_s0;
    logic signed [16:0] lin_s0;
    logic signed [16:0] sx;
    logic signed [16:0] dzs;
    stick_t      st_s0;

    logic [15:0] n1_reg, d1_reg;
    logic [31:0] n2_reg, d2_reg;
    logic [15:0] n2b_reg, d2b_reg;
    stick_t      st1_reg, st2_reg, st3_reg;
    logic [47:0] n3_reg, d3_reg;

    always_comb
    begin
        sx     = 17'(sample);
        dzs    = signed'({2'b00, deadzone});
        mag    = sample[15] ? 16'(-sx) : 16'(sample);
        neg_s0 = sample[15];
        n_wide = {1'b0, mag} - {2'b00, deadzone};
        d_s0   = 16'(15'h7fff - deadzone);
        below_s0 = n_wide[16] || (n_wide == 17'd0);
        if (sx < -dzs)
            lin_s0 = sx + dzs;
        else if (sx > dzs)
            lin_s0 = sx - dzs;
        else
            lin_s0 = '0;
        st_s0      = '0;
        st_s0.neg  = neg_s0;
        st_s0.zero = below_s0;
        st_s0.lin  = lin_s0;
        st_s0.force_full = ~below_s0 &&
            ((deadzone == 15'h7fff) || (n_wide[15:0] > d_s0));
    end

    // Stage 1: operands; stage 2: squares; stage 3: cubes.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg  <= n_wide[15:0];
            d1_reg  <= d_s0;
            st1_reg <= st_s0;

            n2_reg  <= n1_reg * n1_reg;
            d2_reg  <= d1_reg * d1_reg;
            n2b_reg <= n1_reg;
            d2b_reg <= d1_reg;
            st2_reg <= st1_reg;

            n3_reg  <= n2_reg * n2b_reg;
            d3_reg  <= d2_reg * d2b_reg;
            st3_reg <= st2_reg;
        end
    end

    // Numerator 32767*n^3 = (n^3 << 15) - n^3, no multiplier needed.
    always_comb
    begin
        result     = st3_reg;
        result.rem = ({16'd0, n3_reg} << QBITS) - {16'd0, n3_reg};
        result.den = d3_reg[45:0];
        result.quo = '0;
    end

endmodule

/* hw/rtl/sdcs_div_cell.sv */
// One restoring-division cell: yields one quotient bit per cycle while enabled.
// Cells are chained; depends on sdcs_pkg.
module sdcs_div_cell (
    input  logic             clk,
    input  logic             en,
    input  logic [5:0]       bit_pos,
    input  sdcs_pkg::stick_t din,
    output sdcs_pkg::stick_t dout
);
    import sdcs_pkg::*;

    stick_t      cell_reg;
    stick_t      cell_next;
    logic [63:0] trial;

    always_comb
    begin
        cell_next = din;
        trial     = {18'd0, din.den} << bit_pos;
        if (din.rem >= trial)
        begin
            cell_next.rem = din.rem - trial;
            cell_next.quo = din.quo | (QBITS'(1) << bit_pos);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            cell_reg <= cell_next;
    end

    assign dout = cell_reg;

endmodule
